// ===== hw/rtl/hrlvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_pkg
// Shared types, constants and the CORDIC arctangent table of the heading and
// velocity control unit.
// ----------------------------------------------------------------------------
package hrlvc_pkg;

    localparam int VEL_W       = 16;
    localparam int DT_W        = 16;
    localparam int HEAD_W      = 16;
    localparam int FORCE_W     = 32;
    localparam int IDLE_W      = 24;
    localparam int YAW_W       = 18;
    localparam int MASS_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 18;
    localparam int CORDIC_W    = 36;
    localparam int ANG_W       = 32;
    localparam int ATAN_IDX_W  = 5;
    localparam int MASS10_W    = 20;
    localparam int DIFF_W      = VEL_W + 1;
    localparam int PROD_W      = DIFF_W + MASS10_W + 1;
    localparam int SQ_W        = 2 * VEL_W;
    localparam int LIM_W       = YAW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_YAW_RATE = 8'd0,
        REG_BODY_MASS    = 8'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ITER,
        ST_TURN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic iter;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic iter_last;
    } status_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/hrlvc_tick_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_tick_if
// Input channel carrying one control tick word.
// ----------------------------------------------------------------------------
interface hrlvc_tick_if
    import hrlvc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [VEL_W-1:0]  target_vx;
    logic signed [VEL_W-1:0]  target_vz;
    logic signed [VEL_W-1:0]  measured_vx;
    logic signed [VEL_W-1:0]  measured_vz;
    logic        [DT_W-1:0]   tick_length;
    logic                     ground_contact;
    logic                     jump_request;

    modport source (
        output valid, target_vx, target_vz, measured_vx, measured_vz,
        output tick_length, ground_contact, jump_request,
        input  ready
    );

    modport sink (
        input  valid, target_vx, target_vz, measured_vx, measured_vz,
        input  tick_length, ground_contact, jump_request,
        output ready
    );
endinterface

// ===== hw/rtl/hrlvc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_result_if
// Output channel carrying one result word per control tick.
// ----------------------------------------------------------------------------
interface hrlvc_result_if
    import hrlvc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_z;
    logic                      jump_launch;
    logic        [IDLE_W-1:0]  idle_time;

    modport source (
        output valid, heading, force_x, force_z, jump_launch, idle_time,
        input  ready
    );

    modport sink (
        input  valid, heading, force_x, force_z, jump_launch, idle_time,
        output ready
    );
endinterface

// ===== hw/rtl/hrlvc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hrlvc_cfg_if
    import hrlvc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== hw/rtl/hrlvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_ctrl
// Sequencer of the control unit: accepts a tick, steps the datapath through
// the multiply, CORDIC and turn phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
module hrlvc_ctrl
    import hrlvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_valid,
    output logic    tick_ready,
    output logic    result_valid,
    input  logic    result_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                if (status.iter_last)
                begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        tick_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                cmd.load   = tick_valid;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_ITER:
            begin
                cmd.iter = 1'b1;
            end
            ST_TURN:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== hw/rtl/hrlvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlvc_datapath
// Configuration registers, tick capture, force and limit multipliers, the
// iterative CORDIC arctangent and the heading, jump and idle state.
// ----------------------------------------------------------------------------
module hrlvc_datapath
    import hrlvc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [VEL_W-1:0]   target_vx,
    input  logic signed [VEL_W-1:0]   target_vz,
    input  logic signed [VEL_W-1:0]   measured_vx,
    input  logic signed [VEL_W-1:0]   measured_vz,
    input  logic        [DT_W-1:0]    tick_length,
    input  logic                      ground_contact,
    input  logic                      jump_request,
    output logic signed [HEAD_W-1:0]  heading,
    output logic signed [FORCE_W-1:0] force_x,
    output logic signed [FORCE_W-1:0] force_z,
    output logic                      jump_launch,
    output logic        [IDLE_W-1:0]  idle_time
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic signed [PROD_W-1:0] F_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] F_MIN = -PROD_W'(64'sd2147483648);
    localparam logic [SQ_W:0] SPEED_MIN = (SQ_W+1)'(65536);
    localparam logic [IDLE_W:0] IDLE_MAX = {1'b0, {IDLE_W{1'b1}}};

    logic [YAW_W-1:0]  yaw_rate_reg;
    logic [MASS_W-1:0] mass_reg;

    logic signed [VEL_W-1:0] tvx_reg, tvz_reg, mvx_reg, mvz_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    contact_reg;
    logic                    req_reg;

    logic [SQ_W-1:0]          sqx_reg, sqz_reg;
    logic signed [PROD_W-1:0] fx_prod_reg, fz_prod_reg;
    logic [LIM_W-1:0]         lim_reg;

    logic signed [CORDIC_W-1:0] cx_reg, cy_reg;
    logic [ANG_W-1:0]           ang_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [HEAD_W-1:0]         head_reg;
    logic                      jump_pend_reg;
    logic [IDLE_W-1:0]         idle_reg;
    logic signed [FORCE_W-1:0] fx_out_reg, fz_out_reg;
    logic                      launch_reg;

    logic signed [CORDIC_W-1:0] x_init, y_init, xs, ys;
    logic [ANG_W-1:0]           atan_val;
    logic [MASS10_W-1:0]        mass10;
    logic signed [DIFF_W-1:0]   dx, dz;
    logic [YAW_W+DT_W-1:0]      lim_prod;
    logic                       moving;
    logic                       idle_tick;
    logic [HEAD_W-1:0]          target_head;
    logic [HEAD_W-1:0]          delta;
    logic signed [LIM_W:0]      delta_ext, lim_ext, delta_clamp;
    logic [HEAD_W-1:0]          head_turned;
    logic [IDLE_W:0]            idle_sum;
    logic                       pend;
    logic signed [FORCE_W-1:0]  fx_sat, fz_sat;

    function automatic logic signed [FORCE_W-1:0] sat_force(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] sh;
        logic signed [FORCE_W-1:0] res;
        sh = prod >>> 8;
        if (sh > F_MAX)
        begin
            res = F_MAX[FORCE_W-1:0];
        end
        else if (sh < F_MIN)
        begin
            res = F_MIN[FORCE_W-1:0];
        end
        else
        begin
            res = sh[FORCE_W-1:0];
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_rate_reg <= YAW_W'(131072);
            mass_reg     <= MASS_W'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_YAW_RATE: yaw_rate_reg <= cfg_data[YAW_W-1:0];
                REG_BODY_MASS:    mass_reg     <= cfg_data[MASS_W-1:0];
                default:          ;
            endcase
        end
    end

    // CORDIC start vector: x = vz, y = vx, folded into the right half plane.
    always_comb
    begin
        x_init = CORDIC_W'(signed'({target_vz, 16'h0000}));
        y_init = CORDIC_W'(signed'({target_vx, 16'h0000}));
        if (target_vz[VEL_W-1])
        begin
            x_init = -x_init;
            y_init = -y_init;
        end
    end

    assign xs       = cx_reg >>> cnt_reg;
    assign ys       = cy_reg >>> cnt_reg;
    assign atan_val = atan_entry(ATAN_IDX_W'(cnt_reg));

    assign mass10   = (MASS10_W'(mass_reg) << 3) + (MASS10_W'(mass_reg) << 1);
    assign dx       = DIFF_W'(tvx_reg) - DIFF_W'(mvx_reg);
    assign dz       = DIFF_W'(tvz_reg) - DIFF_W'(mvz_reg);
    assign lim_prod = (YAW_W+DT_W)'(yaw_rate_reg) * (YAW_W+DT_W)'(dt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tvx_reg     <= target_vx;
            tvz_reg     <= target_vz;
            mvx_reg     <= measured_vx;
            mvz_reg     <= measured_vz;
            dt_reg      <= tick_length;
            contact_reg <= ground_contact;
            req_reg     <= jump_request;
            cx_reg      <= x_init;
            cy_reg      <= y_init;
            ang_reg     <= target_vz[VEL_W-1] ? 32'h8000_0000 : '0;
            cnt_reg     <= '0;
        end
        else if (cmd.iter)
        begin
            if (cy_reg > 0)
            begin
                cx_reg  <= cx_reg + ys;
                cy_reg  <= cy_reg - xs;
                ang_reg <= ang_reg + atan_val;
            end
            else
            begin
                cx_reg  <= cx_reg - ys;
                cy_reg  <= cy_reg + xs;
                ang_reg <= ang_reg - atan_val;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            sqx_reg     <= SQ_W'(tvx_reg * tvx_reg);
            sqz_reg     <= SQ_W'(tvz_reg * tvz_reg);
            fx_prod_reg <= PROD_W'(dx) * PROD_W'(signed'({1'b0, mass10}));
            fz_prod_reg <= PROD_W'(dz) * PROD_W'(signed'({1'b0, mass10}));
            lim_reg     <= lim_prod[YAW_W+DT_W-1:DT_W];
        end
        if (cmd.commit)
        begin
            fx_out_reg <= fx_sat;
            fz_out_reg <= fz_sat;
        end
    end

    assign status.iter_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    // Turn toward the target heading, clamped to the rate limit; also form the idle, jump and saturated force values.
    always_comb
    begin
        moving      = ({1'b0, sqx_reg} + {1'b0, sqz_reg}) > SPEED_MIN;
        idle_tick   = !moving && contact_reg;
        target_head = ang_reg[ANG_W-1:HEAD_W] + HEAD_W'(ang_reg[HEAD_W-1]);
        delta       = target_head - head_reg;
        delta_ext   = (LIM_W+1)'(signed'(delta));
        lim_ext     = signed'({1'b0, lim_reg});
        if (delta_ext > lim_ext)
        begin
            delta_clamp = lim_ext;
        end
        else if (delta_ext < -lim_ext)
        begin
            delta_clamp = -lim_ext;
        end
        else
        begin
            delta_clamp = delta_ext;
        end
        head_turned = head_reg + delta_clamp[HEAD_W-1:0];
        idle_sum    = {1'b0, idle_reg} + (IDLE_W+1)'(dt_reg);
        pend        = jump_pend_reg || req_reg;
        fx_sat      = sat_force(fx_prod_reg);
        fz_sat      = sat_force(fz_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            jump_pend_reg <= 1'b0;
            idle_reg      <= '0;
            launch_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (moving)
            begin
                head_reg <= head_turned;
            end
            jump_pend_reg <= pend && !contact_reg;
            launch_reg    <= pend && contact_reg;
            if (!idle_tick)
            begin
                idle_reg <= '0;
            end
            else if (idle_sum > IDLE_MAX)
            begin
                idle_reg <= IDLE_MAX[IDLE_W-1:0];
            end
            else
            begin
                idle_reg <= idle_sum[IDLE_W-1:0];
            end
        end
    end

    assign heading     = signed'(head_reg);
    assign force_x     = fx_out_reg;
    assign force_z     = fz_out_reg;
    assign jump_launch = launch_reg;
    assign idle_time   = idle_reg;

endmodule

// ===== hw/rtl/heading_rate_limited_velocity_control_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_rate_limited_velocity_control_unit
// Per-tick heading tracker with rate-limited turning and proportional
// horizontal drive force, jump latch and idle timer.
// ----------------------------------------------------------------------------
// Each accepted tick word is worked through in turn: the word is captured,
// the squared-speed, force and turn-limit multipliers run, CORDIC_STEPS
// iterations of the iterative arctangent follow, and then the turn is
// applied and the result loaded. The
// result sits in an output register, so a finished word may wait for the
// sink while the next tick is accepted; the turn cycle stalls only when an
// earlier result is still untaken. Configuration writes are always taken and
// should only be issued between ticks.
module heading_rate_limited_velocity_control_unit
    import hrlvc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input logic             clk,
    input logic             rst_n,
    hrlvc_tick_if.sink      tick,
    hrlvc_result_if.source  result,
    hrlvc_cfg_if.sink       cfg
);

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    hrlvc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    hrlvc_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .target_vx      (tick.target_vx),
        .target_vz      (tick.target_vz),
        .measured_vx    (tick.measured_vx),
        .measured_vz    (tick.measured_vz),
        .tick_length    (tick.tick_length),
        .ground_contact (tick.ground_contact),
        .jump_request   (tick.jump_request),
        .heading        (result.heading),
        .force_x        (result.force_x),
        .force_z        (result.force_z),
        .jump_launch    (result.jump_launch),
        .idle_time      (result.idle_time)
    );

    // A taken tick keeps the input closed until its result is loaded.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> !tick.ready
    ) else $error("tick accepted while a previous tick was in progress");

    // A new result never overwrites one the sink has not taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!result.valid || result.ready)
    ) else $error("result overwritten before it was taken");

    // Loading a result always raises the output valid.
    a_commit_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result.valid
    ) else $error("result loaded without valid");

    // The input is never open while a result is being loaded.
    a_commit_closed: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !tick.ready
    ) else $error("input open during result load");

endmodule
